FILE: rtl/rfve_pkg.sv
// Package for the row field varint encoder: constants, types and varint helpers.
package rfve_pkg;

    localparam int unsigned MAX_BYTES = 13;
    localparam int unsigned BUF_W     = MAX_BYTES * 8;
    localparam int unsigned VAR_BYTES = 10;
    localparam int unsigned VAR_W     = VAR_BYTES * 8;

    localparam logic [7:0] FIELD_TAG = 8'h0A;
    localparam logic       SIGN_NEG  = 1'b1;
    localparam logic       SIGN_POS  = 1'b0;

    localparam logic [2:0] KIND_NULL     = 3'd0;
    localparam logic [2:0] KIND_INT      = 3'd1;
    localparam logic [2:0] KIND_DATE     = 3'd2;
    localparam logic [2:0] KIND_TIME     = 3'd3;
    localparam logic [2:0] KIND_DATETIME = 3'd4;

    // Varint of up to ten bytes; bytes past len are zero.
    typedef struct packed {
        logic [VAR_W-1:0] bytes;
        logic [3:0]       len;
    } varint_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] int_value;
        logic        is_unsigned;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [9:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] microsecond;
        logic        negative;
    } item_t;

    function automatic varint_t varint_enc(input logic [63:0] v);
        logic [69:0] ext;
        logic [69:0] rest;
        logic        more;
        varint_t     r;
        ext     = {6'b0, v};
        r.bytes = '0;
        r.len   = 4'd1;
        for (int i = 0; i < VAR_BYTES; i++)
        begin
            rest = ext >> (7 * (i + 1));
            more = |rest;
            r.bytes[8*i +: 8] = {more, ext[7*i +: 7]};
            if (ext[7*i +: 7] != 7'd0)
                r.len = 4'(i + 1);
        end
        return r;
    endfunction

    // OR a varint into the field buffer starting at byte pos.
    function automatic logic [BUF_W-1:0] place(input logic [BUF_W-1:0] buf_in,
                                               input logic [3:0] pos,
                                               input varint_t vi);
        logic [BUF_W-1:0] wide;
        wide = {{(BUF_W-VAR_W){1'b0}}, vi.bytes};
        return buf_in | (wide << {pos, 3'b000});
    endfunction

endpackage

FILE: rtl/rfve_if.sv
// Valid/ready channel interfaces for column values in and encoded bytes out.
interface rfve_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] int_value;
    logic        is_unsigned;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [9:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] microsecond;
    logic        negative;

    modport source (output valid, kind, int_value, is_unsigned, year, month, day,
                    hour, minute, second, microsecond, negative, input ready);
    modport sink (input valid, kind, int_value, is_unsigned, year, month, day,
                  hour, minute, second, microsecond, negative, output ready);
endinterface

interface rfve_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

FILE: rtl/row_field_varint_encoder.sv
// Row field varint encoder: one typed column value in, its protobuf field bytes out.
// A column value is taken into an input register and encoded in one pass into a field buffer
// of up to 13 bytes (tag 0x0A, payload length, payload) once that buffer is free; the field is
// then sent one byte per word with last set on the final byte. A field is 2 to 13 words long
// (null 2, integer 3 to 12, date 5 or 6, time 3 to 10, datetime 5 to 13), so an item occupies
// the output port for one word per field byte; that one-byte output port sets the rate. While
// a field drains, the next value waits in the input register and is loaded as the last byte
// leaves, so its field follows straight on from the previous one.
module row_field_varint_encoder (
    input  logic         clk,
    input  logic         rst_n,
    rfve_in_if.sink      din,
    rfve_out_if.source   dout
);

    rfve_pkg::item_t           in_reg;
    logic                      in_full_reg;
    logic [rfve_pkg::BUF_W-1:0] buf_reg;
    logic [rfve_pkg::BUF_W-1:0] buf_next;
    logic [3:0]                rem_reg;
    logic [3:0]                rem_next;

    logic load;
    logic out_take;

    assign out_take  = dout.valid && dout.ready;
    assign load      = in_full_reg && (rem_reg == 4'd0 || (out_take && dout.last));
    assign din.ready = !in_full_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (din.ready)
            in_full_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_reg.kind        <= din.kind;
            in_reg.int_value   <= din.int_value;
            in_reg.is_unsigned <= din.is_unsigned;
            in_reg.year        <= din.year;
            in_reg.month       <= din.month;
            in_reg.day         <= din.day;
            in_reg.hour        <= din.hour;
            in_reg.minute      <= din.minute;
            in_reg.second      <= din.second;
            in_reg.microsecond <= din.microsecond;
            in_reg.negative    <= din.negative;
        end
    end

    // Field encoder
    rfve_pkg::varint_t v_int, v_year, v_month, v_day, v_hour, v_min, v_sec, v_us, v_sign;
    logic [63:0] int_zz;
    logic        on_h, on_mi, on_s, on_us;
    logic [rfve_pkg::BUF_W-1:0] enc_buf;
    logic [3:0]  pos;
    logic [3:0]  plen;

    always_comb
    begin
        int_zz = in_reg.is_unsigned ? in_reg.int_value
               : ({in_reg.int_value[62:0], 1'b0} ^ {64{in_reg.int_value[63]}});
        v_int   = rfve_pkg::varint_enc(int_zz);
        v_year  = rfve_pkg::varint_enc({50'b0, in_reg.year});
        v_month = rfve_pkg::varint_enc({60'b0, in_reg.month});
        v_day   = rfve_pkg::varint_enc({59'b0, in_reg.day});
        v_hour  = rfve_pkg::varint_enc({54'b0, in_reg.hour});
        v_min   = rfve_pkg::varint_enc({58'b0, in_reg.minute});
        v_sec   = rfve_pkg::varint_enc({58'b0, in_reg.second});
        v_us    = rfve_pkg::varint_enc({44'b0, in_reg.microsecond});

        v_sign.bytes = '0;
        v_sign.bytes[0] = in_reg.negative ? rfve_pkg::SIGN_NEG : rfve_pkg::SIGN_POS;
        v_sign.len = 4'd1;

        // trailing zero time parts are dropped
        on_us = in_reg.microsecond != 20'd0;
        on_s  = on_us || in_reg.second != 6'd0;
        on_mi = on_s || in_reg.minute != 6'd0;
        on_h  = on_mi || in_reg.hour != 10'd0;
        if (!on_h)
            v_hour = '0;
        if (!on_mi)
            v_min = '0;
        if (!on_s)
            v_sec = '0;
        if (!on_us)
            v_us = '0;

        enc_buf = '0;
        enc_buf[7:0] = rfve_pkg::FIELD_TAG;
        pos = 4'd2;
        unique case (in_reg.kind)
            rfve_pkg::KIND_INT:
            begin
                enc_buf = rfve_pkg::place(enc_buf, pos, v_int);
                pos = pos + v_int.len;
            end
            rfve_pkg::KIND_DATE, rfve_pkg::KIND_DATETIME:
            begin
                enc_buf = rfve_pkg::place(enc_buf, pos, v_year);
                pos = pos + v_year.len;
                enc_buf = rfve_pkg::place(enc_buf, pos, v_month);
                pos = pos + v_month.len;
                enc_buf = rfve_pkg::place(enc_buf, pos, v_day);
                pos = pos + v_day.len;
            end
            rfve_pkg::KIND_TIME:
            begin
                enc_buf = rfve_pkg::place(enc_buf, pos, v_sign);
                pos = pos + v_sign.len;
            end
            default:
            begin
            end
        endcase
        if (in_reg.kind == rfve_pkg::KIND_TIME || in_reg.kind == rfve_pkg::KIND_DATETIME)
        begin
            enc_buf = rfve_pkg::place(enc_buf, pos, v_hour);
            pos = pos + v_hour.len;
            enc_buf = rfve_pkg::place(enc_buf, pos, v_min);
            pos = pos + v_min.len;
            enc_buf = rfve_pkg::place(enc_buf, pos, v_sec);
            pos = pos + v_sec.len;
            enc_buf = rfve_pkg::place(enc_buf, pos, v_us);
            pos = pos + v_us.len;
        end
        plen = pos - 4'd2;
        enc_buf[15:8] = {4'b0, plen};
    end

    // Output buffer: shifts one byte out per word taken
    always_comb
    begin
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (load)
        begin
            buf_next = enc_buf;
            rem_next = pos;
        end
        else if (out_take)
        begin
            buf_next = buf_reg >> 8;
            rem_next = rem_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 4'd0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign dout.valid    = rem_reg != 4'd0;
    assign dout.out_byte = buf_reg[7:0];
    assign dout.last     = rem_reg == 4'd1;

`ifndef ASSERT_OFF
    a_load_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> dout.valid && rem_reg >= 4'd2 && rem_reg <= 4'(rfve_pkg::MAX_BYTES))
        else $error("field loaded with impossible length");

    a_no_gap_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !dout.last |=> dout.valid)
        else $error("field stopped before its last byte");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && dout.last && !load |=> !dout.valid)
        else $error("bytes sent after the last byte of a field");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !load |=> in_full_reg)
        else $error("pending item dropped");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !dout.valid |-> load)
        else $error("pending item not loaded into idle output buffer");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for row_field_varint_encoder: random and directed column values, byte-level scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_VALUES = 260;
    localparam int unsigned CYCLE_LIMIT   = 250000;
    localparam int unsigned DRAIN_CYCLES  = 20;

    // Expected field bytes in order of arrival, with the last marker beside each byte.
    class field_scoreboard;
        logic [7:0] exp_byte[$];
        logic       exp_last[$];
        logic [7:0] scratch[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return exp_byte.size();
        endfunction

        function void put_scratch(logic [7:0] b);
            scratch = {scratch, b};
        endfunction

        function void put_expected(logic [7:0] b, logic l);
            exp_byte = {exp_byte, b};
            exp_last = {exp_last, l};
        endfunction

        function void add_varint(logic [63:0] v);
            do
            begin
                put_scratch({(v >= 64'h80), v[6:0]});
                v = v >> 7;
            end
            while (v != 64'd0);
        endfunction

        // Trailing zero parts are dropped.
        function void add_time_parts(logic [9:0] h, logic [5:0] mi, logic [5:0] s,
                                     logic [19:0] us);
            if (h != 0 || mi != 0 || s != 0 || us != 0)
                add_varint(64'(h));
            if (mi != 0 || s != 0 || us != 0)
                add_varint(64'(mi));
            if (s != 0 || us != 0)
                add_varint(64'(s));
            if (us != 0)
                add_varint(64'(us));
        endfunction

        function void note_value(rfve_pkg::item_t v);
            logic [7:0]  payload[$];
            logic [63:0] zz;
            int          total;
            scratch.delete();
            case (v.kind)
                rfve_pkg::KIND_INT:
                begin
                    zz = v.is_unsigned ? v.int_value
                                       : ((v.int_value << 1) ^ {64{v.int_value[63]}});
                    add_varint(zz);
                end
                rfve_pkg::KIND_DATE:
                begin
                    add_varint(64'(v.year));
                    add_varint(64'(v.month));
                    add_varint(64'(v.day));
                end
                rfve_pkg::KIND_TIME:
                begin
                    put_scratch(v.negative ? 8'(rfve_pkg::SIGN_NEG) : 8'(rfve_pkg::SIGN_POS));
                    add_time_parts(v.hour, v.minute, v.second, v.microsecond);
                end
                rfve_pkg::KIND_DATETIME:
                begin
                    add_varint(64'(v.year));
                    add_varint(64'(v.month));
                    add_varint(64'(v.day));
                    add_time_parts(v.hour, v.minute, v.second, v.microsecond);
                end
                default:
                    ;
            endcase
            payload = scratch;
            scratch.delete();
            put_scratch(rfve_pkg::FIELD_TAG);
            add_varint(64'(payload.size()));
            foreach (payload[i])
                put_scratch(payload[i]);
            total = (scratch.size() > int'(rfve_pkg::MAX_BYTES))
                  ? int'(rfve_pkg::MAX_BYTES) : scratch.size();
            for (int i = 0; i < total; i++)
                put_expected(scratch[i], i == total - 1);
        endfunction

        function void check_byte(logic [7:0] b, logic l);
            logic [7:0] eb;
            logic       el;
            if (exp_byte.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got byte %h last %0d",
                         $time, b, l);
                errors++;
                return;
            end
            eb = exp_byte.pop_front();
            el = exp_last.pop_front();
            if (b !== eb)
            begin
                $display("%0t: out_byte mismatch: expected %h, got %h", $time, eb, b);
                errors++;
            end
            if (l !== el)
            begin
                $display("%0t: last mismatch: expected %0d, got %0d", $time, el, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady;
    int unsigned cycles = 0;

    rfve_pkg::item_t directed[$];

    rfve_in_if  din ();
    rfve_out_if dout ();

    field_scoreboard sb = new();

    row_field_varint_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din.sink),
        .dout  (dout.source)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL row_field_varint_encoder");
            $finish;
        end
    end

    // Output side: random back-pressure, none while steady is set.
    initial
    begin
        dout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            dout.ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
        if (rst_n && dout.valid && dout.ready)
            sb.check_byte(dout.out_byte, dout.last);

    function automatic rfve_pkg::item_t make_value(logic [2:0] k, logic [63:0] iv, logic uns,
                                                   logic [13:0] y, logic [3:0] mo,
                                                   logic [4:0] d, logic [9:0] h,
                                                   logic [5:0] mi, logic [5:0] s,
                                                   logic [19:0] us, logic neg);
        rfve_pkg::item_t v;
        v.kind        = k;
        v.int_value   = iv;
        v.is_unsigned = uns;
        v.year        = y;
        v.month       = mo;
        v.day         = d;
        v.hour        = h;
        v.minute      = mi;
        v.second      = s;
        v.microsecond = us;
        v.negative    = neg;
        return v;
    endfunction

    function automatic void add_directed(rfve_pkg::item_t v);
        directed = {directed, v};
    endfunction

    function automatic rfve_pkg::item_t random_value();
        rfve_pkg::item_t v;
        int unsigned     cut;
        if ($urandom_range(99) < 5)
            v.kind = 3'($urandom_range(7, 5));
        else
            v.kind = 3'($urandom_range(4));
        v.int_value   = {$urandom, $urandom} >> $urandom_range(63);
        v.is_unsigned = 1'($urandom_range(1));
        v.negative    = 1'($urandom_range(1));
        if ($urandom_range(9) == 0)
        begin
            // full-width parts, beyond their nominal ranges
            v.year        = 14'($urandom);
            v.month       = 4'($urandom);
            v.day         = 5'($urandom);
            v.hour        = 10'($urandom);
            v.minute      = 6'($urandom);
            v.second      = 6'($urandom);
            v.microsecond = 20'($urandom);
        end
        else
        begin
            v.year        = 14'($urandom_range(9999));
            v.month       = 4'($urandom_range(12));
            v.day         = 5'($urandom_range(31));
            v.hour        = 10'($urandom_range(838));
            v.minute      = 6'($urandom_range(59));
            v.second      = 6'($urandom_range(59));
            v.microsecond = 20'($urandom_range(999999));
        end
        // zero the trailing time parts from a random point on
        cut = $urandom_range(5);
        if (cut <= 0)
            v.hour = '0;
        if (cut <= 1)
            v.minute = '0;
        if (cut <= 2)
            v.second = '0;
        if (cut <= 3)
            v.microsecond = '0;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_value(input rfve_pkg::item_t v);
        while (!steady && $urandom_range(99) < 20)
        begin
            din.valid <= 1'b0;
            @(negedge clk);
        end
        din.valid       <= 1'b1;
        din.kind        <= v.kind;
        din.int_value   <= v.int_value;
        din.is_unsigned <= v.is_unsigned;
        din.year        <= v.year;
        din.month       <= v.month;
        din.day         <= v.day;
        din.hour        <= v.hour;
        din.minute      <= v.minute;
        din.second      <= v.second;
        din.microsecond <= v.microsecond;
        din.negative    <= v.negative;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        sb.note_value(v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        din.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        steady          = 1'b0;
        rst_n           = 1'b0;
        din.valid       = 1'b0;
        din.kind        = rfve_pkg::KIND_NULL;
        din.int_value   = '0;
        din.is_unsigned = 1'b0;
        din.year        = '0;
        din.month       = '0;
        din.day         = '0;
        din.hour        = '0;
        din.minute      = '0;
        din.second      = '0;
        din.microsecond = '0;
        din.negative    = 1'b0;

        add_directed(make_value(rfve_pkg::KIND_NULL, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // unused kind codes come out as a null field; other fields are ignored
        for (int k = 5; k <= 7; k++)
            add_directed(make_value(3'(k), '1, 1, '1, '1, '1, '1, '1, '1, '1, 1));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'd0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'd127, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'd128, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, '1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'h8000_0000_0000_0000, 0,
                                0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_INT, 64'h7FFF_FFFF_FFFF_FFFF, 0,
                                0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_DATE, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_DATE, '0, 0, 9999, 12, 31, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_DATE, '1, 1, '1, '1, '1, '1, '1, '1, '1, 1));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, 838, 0, 0, 0, 1));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, 0, 59, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, 0, 0, 59, 0, 1));
        add_directed(make_value(rfve_pkg::KIND_TIME, '0, 0, 0, 0, 0, '1, '1, '1, '1, 1));
        add_directed(make_value(rfve_pkg::KIND_DATETIME, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_directed(make_value(rfve_pkg::KIND_DATETIME, '0, 0, 128, 2, 29,
                                0, 0, 0, 999999, 0));
        add_directed(make_value(rfve_pkg::KIND_DATETIME, '1, 1, '1, '1, '1,
                                '1, '1, '1, '1, 1));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_value(directed[i]);
        wait_drained();

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            steady <= (i >= 100 && i < 170);
            send_value(random_value());
            if (i == 200)
                wait_drained();
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS row_field_varint_encoder");
        else
            $display("FAIL row_field_varint_encoder");
        $finish;
    end
endmodule
